@@ hw/rtl/ordered_list_engine_core_macros.svh @@
// Assertion macros shared by the ordered list engine RTL.
`ifndef ORDERED_LIST_ENGINE_CORE_MACROS_SVH
`define ORDERED_LIST_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define OLE_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define OLE_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/olist_pkg.sv @@
// Package with the request codes, status codes, state type and shared structs.
`timescale 1ns / 1ps

package olist_pkg;

   localparam int REQ_W = 3;
   localparam int VAL_W = 32;
   localparam int POS_W = 5;

   // Request codes carried on the request word.
   typedef enum logic [REQ_W-1:0] {
      OP_APPEND    = 3'd0,
      OP_PUSH_HEAD = 3'd1,
      OP_INSERT    = 3'd2,
      OP_FIND      = 3'd3,
      OP_READ      = 3'd4,
      OP_DEL_VALUE = 3'd5,
      OP_DEL_POS   = 3'd6,
      OP_CLEAR     = 3'd7
   } op_type;

   // Completion status returned with every response word.
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_MISS  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_MOVE,
      S_MOVE_WR,
      S_PUT,
      S_DONE
   } seq_state_type;

   // Compare results from the shared step unit.
   typedef struct packed {
      logic hit;
      logic at_bound;
      logic next_bound;
   } step_flags_type;

   // One response word.
   typedef struct packed {
      status_type        status;
      logic              found;
      logic [VAL_W-1:0]  value;
      logic [POS_W-1:0]  position;
      logic [POS_W-1:0]  count;
   } result_type;

endpackage

@@ hw/rtl/ordered_list_engine_core.sv @@
// Top level of the ordered list engine: request handshake, sequencer and response register.
//
//   Channel   Handshake              Word fields
//   req       req_valid/req_ready    req_type, req_item_value, req_item_position
//   rsp       rsp_valid/rsp_ready    rsp_status, rsp_found, rsp_result_value,
//                                    rsp_result_position, rsp_entry_count
//
// One request at a time; req_ready is high only while the sequencer is idle.
// Each request passes through decode and done; a find or read adds a scan read and a scan
// compare state per visited entry, each shifted entry adds a move and a move-write state,
// and inserts close with a move and a put state, deletes with a final move state.
// The single registered read port of the entry storage splits each visited entry into a read and a compare state.
// A finished response waits in the output register while the next request is taken;
// the sequencer holds its result when that register is still occupied.
// Synchronous reset empties the list and drops rsp_valid; entries need no clearing.
`timescale 1ns / 1ps
`include "ordered_list_engine_core_macros.svh"

module ordered_list_engine_core import olist_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [REQ_W-1:0]        req_type,
   input  logic signed [VAL_W-1:0] req_item_value,
   input  logic [POS_W-1:0]        req_item_position,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_status,
   output logic                    rsp_found,
   output logic signed [VAL_W-1:0] rsp_result_value,
   output logic [POS_W-1:0]        rsp_result_position,
   output logic [POS_W-1:0]        rsp_entry_count
);

   logic       seq_idle;
   logic       seq_done;
   logic       start;
   logic       out_free;
   result_type seq_res;
   logic       rsp_valid_ff;
   result_type rsp_ff;

   // A request word is taken whenever the sequencer is idle.
   assign req_ready = seq_idle;
   assign start     = req_valid && req_ready;

   // The output register is free when empty or being drained this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;

   olist_seq #(
      .CAPACITY (CAPACITY)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start_i    (start),
      .op_i       (op_type'(req_type)),
      .value_i    (req_item_value),
      .pos_i      (req_item_position),
      .out_free_i (out_free),
      .idle_o     (seq_idle),
      .done_o     (seq_done),
      .res_o      (seq_res)
   );

   // Response valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (seq_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response word register.
   always_ff @(posedge clock) begin
      if (seq_done) rsp_ff <= seq_res;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_ff.status;
   assign rsp_found           = rsp_ff.found;
   assign rsp_result_value    = $signed(rsp_ff.value);
   assign rsp_result_position = rsp_ff.position;
   assign rsp_entry_count     = rsp_ff.count;

   // Checks on the sequencing and on the response contents.
   `OLE_ASSERT_NEXT(a_busy_after_accept, clock, reset, (req_valid && req_ready), !req_ready, "request accepted but engine still ready")
   `OLE_ASSERT_SAME(a_done_needs_room, clock, reset, seq_done, out_free, "response finished while output register occupied")
   `OLE_ASSERT_SAME(a_error_fields_zero, clock, reset, (rsp_valid && (rsp_status != ST_OK)), (!rsp_found && (rsp_result_position == '0) && (rsp_result_value == '0)), "error response carries data")
   `OLE_ASSERT_SAME(a_found_is_ok, clock, reset, (rsp_valid && rsp_found), ((rsp_status == ST_OK) && (rsp_result_position != '0)), "hit reported without ok status")

endmodule

@@ hw/rtl/olist_step.sv @@
// Shared step unit: cursor increment or decrement plus value and bound compares.
`timescale 1ns / 1ps

module olist_step import olist_pkg::*; #(
   parameter int LEN_W = 5
) (
   input  logic [LEN_W-1:0] cur_i,
   input  logic [LEN_W-1:0] bound_i,
   input  logic             down_i,
   input  logic [VAL_W-1:0] data_i,
   input  logic [VAL_W-1:0] key_i,
   output logic [LEN_W-1:0] next_o,
   output step_flags_type   flags_o
);

   // The cursor moves toward the tail for scans and removals, toward the head for inserts.
   assign next_o = down_i ? (cur_i - LEN_W'(1)) : (cur_i + LEN_W'(1));

   // One equality compare on the data and two on the cursor.
   assign flags_o.hit        = (data_i == key_i);
   assign flags_o.at_bound   = (cur_i == bound_i);
   assign flags_o.next_bound = (next_o == bound_i);

endmodule

@@ hw/rtl/olist_seq.sv @@
// Sequencer with the entry storage: decodes a request and walks the list one slot at a time.
`timescale 1ns / 1ps

module olist_seq import olist_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start_i,
   input  op_type           op_i,
   input  logic [VAL_W-1:0] value_i,
   input  logic [POS_W-1:0] pos_i,
   input  logic             out_free_i,
   output logic             idle_o,
   output logic             done_o,
   output result_type       res_o
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LEN_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

   seq_state_type    state_ff, state_in;
   op_type           op_ff;
   logic [VAL_W-1:0] val_ff;
   logic [POS_W-1:0] pos_ff;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] cur_ff, cur_in;
   logic [LEN_W-1:0] slot_ff, slot_in;
   result_type       res_ff, res_in;

   logic [VAL_W-1:0] mem_ff [CAPACITY];
   logic [VAL_W-1:0] rdata_ff;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [VAL_W-1:0] wr_data;

   logic [LEN_W-1:0] step_next;
   logic [LEN_W-1:0] step_bound;
   step_flags_type   flags;

   logic             is_ins;
   logic             is_del;
   logic             is_idx;
   logic             hit;
   logic             full;
   logic             empty;
   logic [CMP_W-1:0] len_ext;
   logic [CMP_W-1:0] pos_ext;
   logic             ins_bad;
   logic             rd_bad;
   logic [LEN_W-1:0] pos_slot;

   // Request classes and range checks.
   assign is_ins   = (op_ff == OP_APPEND) || (op_ff == OP_PUSH_HEAD) || (op_ff == OP_INSERT);
   assign is_del   = (op_ff == OP_DEL_VALUE) || (op_ff == OP_DEL_POS);
   assign is_idx   = (op_ff == OP_READ) || (op_ff == OP_DEL_POS);
   assign full     = (len_ff >= LEN_W'(CAPACITY));
   assign empty    = (len_ff == '0);
   assign len_ext  = CMP_W'(len_ff);
   assign pos_ext  = CMP_W'(pos_ff);
   assign ins_bad  = (pos_ff == '0) || (pos_ext > (len_ext + CMP_W'(1)));
   assign rd_bad   = (pos_ff == '0) || (pos_ext > len_ext);
   assign pos_slot = LEN_W'(pos_ext - CMP_W'(1));

   // Indexed requests take the entry at the cursor without a value match.
   assign hit = flags.hit || is_idx;

   // Inserts stop at the target slot, scans and removals at the list length.
   assign step_bound = is_ins ? slot_ff : len_ff;

   olist_step #(
      .LEN_W (LEN_W)
   ) u_step (
      .cur_i   (cur_ff),
      .bound_i (step_bound),
      .down_i  (is_ins),
      .data_i  (rdata_ff),
      .key_i   (val_ff),
      .next_o  (step_next),
      .flags_o (flags)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start_i) state_in = S_DECODE;
         end
         S_DECODE: begin
            unique case (op_ff) inside
               OP_APPEND, OP_PUSH_HEAD: state_in = full ? S_DONE : S_MOVE;
               OP_INSERT:               state_in = (full || ins_bad) ? S_DONE : S_MOVE;
               OP_FIND, OP_DEL_VALUE:   state_in = empty ? S_DONE : S_SCAN_RD;
               OP_READ, OP_DEL_POS:     state_in = (empty || rd_bad) ? S_DONE : S_SCAN_RD;
               default:                 state_in = S_DONE;
            endcase
         end
         S_SCAN_RD: state_in = S_SCAN_CMP;
         S_SCAN_CMP: begin
            if (hit) state_in = is_del ? S_MOVE : S_DONE;
            else if (flags.next_bound) state_in = S_DONE;
            else state_in = S_SCAN_RD;
         end
         S_MOVE: begin
            if (is_ins) state_in = flags.at_bound ? S_PUT : S_MOVE_WR;
            else state_in = flags.next_bound ? S_DONE : S_MOVE_WR;
         end
         S_MOVE_WR: state_in = S_MOVE;
         S_PUT:     state_in = S_DONE;
         S_DONE: begin
            if (out_free_i) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Handshake and storage port controls.
   always_comb begin
      idle_o  = (state_ff == S_IDLE);
      done_o  = (state_ff == S_DONE) && out_free_i;
      rd_en   = 1'b0;
      rd_addr = cur_ff[IDX_W-1:0];
      wr_en   = 1'b0;
      wr_addr = cur_ff[IDX_W-1:0];
      wr_data = rdata_ff;
      unique case (state_ff)
         S_SCAN_RD: rd_en = 1'b1;
         S_MOVE: begin
            rd_en   = is_ins ? !flags.at_bound : !flags.next_bound;
            rd_addr = step_next[IDX_W-1:0];
         end
         S_MOVE_WR: wr_en = 1'b1;
         S_PUT: begin
            wr_en   = 1'b1;
            wr_addr = slot_ff[IDX_W-1:0];
            wr_data = val_ff;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   // Cursor, length, target slot and result updates.
   always_comb begin
      cur_in  = cur_ff;
      len_in  = len_ff;
      slot_in = slot_ff;
      res_in  = res_ff;
      unique case (state_ff)
         S_DECODE: begin
            res_in = '0;
            res_in.status = ST_OK;
            unique case (op_ff) inside
               OP_APPEND: begin
                  if (full) res_in.status = ST_FULL;
                  slot_in = len_ff;
                  cur_in  = len_ff;
               end
               OP_PUSH_HEAD: begin
                  if (full) res_in.status = ST_FULL;
                  slot_in = '0;
                  cur_in  = len_ff;
               end
               OP_INSERT: begin
                  if (full) res_in.status = ST_FULL;
                  else if (ins_bad) res_in.status = ST_RANGE;
                  slot_in = pos_slot;
                  cur_in  = len_ff;
               end
               OP_FIND, OP_DEL_VALUE: begin
                  if (empty) res_in.status = ST_MISS;
                  cur_in = '0;
               end
               OP_READ, OP_DEL_POS: begin
                  if (empty) res_in.status = ST_MISS;
                  else if (rd_bad) res_in.status = ST_RANGE;
                  cur_in = pos_slot;
               end
               default: len_in = '0;
            endcase
         end
         S_SCAN_CMP: begin
            if (hit) begin
               res_in.found    = !is_del;
               res_in.value    = rdata_ff;
               res_in.position = POS_W'(step_next);
            end else if (flags.next_bound) begin
               res_in.status = ST_MISS;
            end else begin
               cur_in = step_next;
            end
         end
         S_MOVE: begin
            if (!is_ins && flags.next_bound) len_in = len_ff - LEN_W'(1);
         end
         S_MOVE_WR: cur_in = step_next;
         S_PUT:     len_in = len_ff + LEN_W'(1);
         default: begin
            cur_in = cur_ff;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         len_ff   <= '0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
      end
   end

   // Request capture and working registers.
   always_ff @(posedge clock) begin
      if (start_i && (state_ff == S_IDLE)) begin
         op_ff  <= op_i;
         val_ff <= value_i;
         pos_ff <= pos_i;
      end
      cur_ff  <= cur_in;
      slot_ff <= slot_in;
      res_ff  <= res_in;
   end

   // Entry storage: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rdata_ff <= mem_ff[rd_addr];
   end

   // The count reflects the length after the request has finished.
   always_comb begin
      res_o       = res_ff;
      res_o.count = POS_W'(len_ff);
   end

endmodule
